>>> hdl/rgbw_pkg.sv
// ----------------------------------------------------------------------------
// rgbw_pkg
// Shared codes and types for the RGBW LED line serializer.
// ----------------------------------------------------------------------------
package rgbw_pkg;

    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_BIT_PERIOD  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_T0_HIGH     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_T1_HIGH     = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RESET_TICKS = 2'd3;

    localparam int BIT_PERIOD_RST  = 250;
    localparam int T0_HIGH_RST     = 60;
    localparam int T1_HIGH_RST     = 120;
    localparam int RESET_TICKS_RST = 60000;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_BITS = 2'd1;
    localparam logic [1:0] PH_GAP  = 2'd2;

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    typedef struct packed {
        logic line_level;
        logic pixel_taken;
        logic busy_res;
        logic frame_done;
    } result_t;

endpackage

>>> hdl/rgbw_led_pulse_serializer.sv
// ----------------------------------------------------------------------------
// rgbw_led_pulse_serializer
// Single-wire RGBW LED line serializer: input register, line step logic,
// result register.
// ----------------------------------------------------------------------------
// Each transaction moves from the input register to the result register.
// Throughput: one transaction per cycle; the input register advances into
// the line step whenever the result register is empty or being taken.
// Reset: rst_n clears all control state; timing registers return to
// 250 / 60 / 120 / 60000 ticks. No clearing pass.
module rgbw_led_pulse_serializer
    import rgbw_pkg::*;
#(
    parameter int PIXEL_BITS = 32,
    parameter int TICK_WIDTH = 12,
    parameter int GAP_WIDTH  = 20,
    parameter int CFG_W      = 20
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  logic                   kind,
    input  logic [7:0]             green,
    input  logic [7:0]             red,
    input  logic [7:0]             blue,
    input  logic [7:0]             white,
    input  logic                   last_pixel,
    output logic                   result_valid,
    input  logic                   result_ready,
    output logic                   line_level,
    output logic                   pixel_taken,
    output logic                   busy_res,
    output logic                   frame_done
);

    logic [TICK_WIDTH-1:0] bit_period;
    logic [TICK_WIDTH-1:0] t0_high;
    logic [TICK_WIDTH-1:0] t1_high;
    logic [GAP_WIDTH-1:0]  reset_ticks;

    logic                  in_valid_reg;
    logic                  kind_reg;
    logic [PIXEL_BITS-1:0] pixel_reg;
    logic                  last_reg;
    logic [31:0]           pixel_full;

    logic                  res_valid_reg;
    result_t               res_reg;
    result_t               step_result;
    logic                  advance;

    assign pixel_full = {green, red, blue, white};
    assign advance    = in_valid_reg && (!res_valid_reg || result_ready);
    assign item_ready = !in_valid_reg || advance;

    rgbw_cfg_regs #(
        .TICK_WIDTH (TICK_WIDTH),
        .GAP_WIDTH  (GAP_WIDTH),
        .CFG_W      (CFG_W)
    ) u_cfg_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .bit_period  (bit_period),
        .t0_high     (t0_high),
        .t1_high     (t1_high),
        .reset_ticks (reset_ticks)
    );

    rgbw_line_core #(
        .PIXEL_BITS (PIXEL_BITS),
        .TICK_WIDTH (TICK_WIDTH),
        .GAP_WIDTH  (GAP_WIDTH)
    ) u_line_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (advance),
        .kind        (kind_reg),
        .pixel       (pixel_reg),
        .last_pixel  (last_reg),
        .bit_period  (bit_period),
        .t0_high     (t0_high),
        .t1_high     (t1_high),
        .reset_ticks (reset_ticks),
        .result      (step_result)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            kind_reg  <= kind;
            pixel_reg <= pixel_full[31 -: PIXEL_BITS];
            last_reg  <= last_pixel;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= step_result;
        end
    end

    assign result_valid = res_valid_reg;
    assign line_level   = res_reg.line_level;
    assign pixel_taken  = res_reg.pixel_taken;
    assign busy_res     = res_reg.busy_res;
    assign frame_done   = res_reg.frame_done;

endmodule

>>> hdl/rgbw_cfg_regs.sv
// ----------------------------------------------------------------------------
// rgbw_cfg_regs
// Timing registers of the serializer, written through a plain write port.
// ----------------------------------------------------------------------------
module rgbw_cfg_regs
    import rgbw_pkg::*;
#(
    parameter int TICK_WIDTH = 12,
    parameter int GAP_WIDTH  = 20,
    parameter int CFG_W      = 20
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    output logic [TICK_WIDTH-1:0]  bit_period,
    output logic [TICK_WIDTH-1:0]  t0_high,
    output logic [TICK_WIDTH-1:0]  t1_high,
    output logic [GAP_WIDTH-1:0]   reset_ticks
);

    logic [TICK_WIDTH-1:0] bit_period_reg;
    logic [TICK_WIDTH-1:0] t0_high_reg;
    logic [TICK_WIDTH-1:0] t1_high_reg;
    logic [GAP_WIDTH-1:0]  reset_ticks_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg  <= TICK_WIDTH'(BIT_PERIOD_RST);
            t0_high_reg     <= TICK_WIDTH'(T0_HIGH_RST);
            t1_high_reg     <= TICK_WIDTH'(T1_HIGH_RST);
            reset_ticks_reg <= GAP_WIDTH'(RESET_TICKS_RST);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_BIT_PERIOD:  bit_period_reg  <= cfg_data[TICK_WIDTH-1:0];
                REG_T0_HIGH:     t0_high_reg     <= cfg_data[TICK_WIDTH-1:0];
                REG_T1_HIGH:     t1_high_reg     <= cfg_data[TICK_WIDTH-1:0];
                REG_RESET_TICKS: reset_ticks_reg <= cfg_data[GAP_WIDTH-1:0];
                default:         ;
            endcase
        end
    end

    assign bit_period  = bit_period_reg;
    assign t0_high     = t0_high_reg;
    assign t1_high     = t1_high_reg;
    assign reset_ticks = reset_ticks_reg;

endmodule

>>> hdl/rgbw_line_core.sv
// ----------------------------------------------------------------------------
// rgbw_line_core
// Line state: hold register, bit shifter, tick and gap counters; one step per
// transaction, result formed combinationally.
// ----------------------------------------------------------------------------
module rgbw_line_core
    import rgbw_pkg::*;
#(
    parameter int PIXEL_BITS = 32,
    parameter int TICK_WIDTH = 12,
    parameter int GAP_WIDTH  = 20
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step_en,
    input  logic                  kind,
    input  logic [PIXEL_BITS-1:0] pixel,
    input  logic                  last_pixel,
    input  logic [TICK_WIDTH-1:0] bit_period,
    input  logic [TICK_WIDTH-1:0] t0_high,
    input  logic [TICK_WIDTH-1:0] t1_high,
    input  logic [GAP_WIDTH-1:0]  reset_ticks,
    output result_t               result
);

    localparam int BL_W = $clog2(PIXEL_BITS + 1);

    logic [PIXEL_BITS-1:0] shift_reg, shift_next;
    logic [BL_W-1:0]       bits_left_reg, bits_left_next;
    logic [TICK_WIDTH-1:0] tick_reg, tick_next;
    logic [1:0]            phase_reg, phase_next;
    logic [GAP_WIDTH-1:0]  gap_reg, gap_next;
    logic [PIXEL_BITS-1:0] held_pixel_reg, held_pixel_next;
    logic                  held_valid_reg, held_valid_next;
    logic                  held_last_reg, held_last_next;
    logic                  cur_last_reg, cur_last_next;

    logic [TICK_WIDTH-1:0] period;
    logic [TICK_WIDTH-1:0] tick_inc;
    logic [GAP_WIDTH-1:0]  gap_inc;
    logic [TICK_WIDTH-1:0] high_time;

    assign period = (bit_period == '0) ? TICK_WIDTH'(1) : bit_period;

    always_comb
    begin
        shift_next      = shift_reg;
        bits_left_next  = bits_left_reg;
        tick_next       = tick_reg;
        phase_next      = phase_reg;
        gap_next        = gap_reg;
        held_pixel_next = held_pixel_reg;
        held_valid_next = held_valid_reg;
        held_last_next  = held_last_reg;
        cur_last_next   = cur_last_reg;
        result          = '0;
        tick_inc        = '0;
        gap_inc         = '0;
        high_time       = '0;

        if (kind == KIND_PIXEL)
        begin
            if (!held_valid_reg)
            begin
                held_pixel_next    = pixel;
                held_last_next     = last_pixel;
                held_valid_next    = 1'b1;
                result.pixel_taken = 1'b1;
            end
            high_time         = shift_reg[PIXEL_BITS-1] ? t1_high : t0_high;
            result.line_level = (phase_reg == PH_BITS) && (tick_reg < high_time);
            result.busy_res   = (phase_reg == PH_BITS) || (phase_reg == PH_GAP);
        end
        else
        begin
            // start the held pixel on an idle line
            if (phase_reg != PH_BITS && phase_reg != PH_GAP)
            begin
                phase_next = PH_IDLE;
                if (held_valid_reg)
                begin
                    shift_next      = held_pixel_reg;
                    bits_left_next  = BL_W'(PIXEL_BITS);
                    tick_next       = '0;
                    cur_last_next   = held_last_reg;
                    held_valid_next = 1'b0;
                    phase_next      = PH_BITS;
                end
            end

            high_time         = shift_next[PIXEL_BITS-1] ? t1_high : t0_high;
            result.busy_res   = (phase_next != PH_IDLE);
            result.line_level = (phase_next == PH_BITS) && (tick_next < high_time);

            if (phase_next == PH_BITS)
            begin
                tick_inc = tick_next + TICK_WIDTH'(1);
                if (tick_inc >= period)
                begin
                    tick_next  = '0;
                    shift_next = {shift_next[PIXEL_BITS-2:0], 1'b0};
                    if (bits_left_next != '0)
                    begin
                        bits_left_next = bits_left_next - BL_W'(1);
                    end
                    if (bits_left_next == '0)
                    begin
                        if (cur_last_next)
                        begin
                            if (reset_ticks == '0)
                            begin
                                result.frame_done = 1'b1;
                                phase_next        = PH_IDLE;
                            end
                            else
                            begin
                                phase_next = PH_GAP;
                                gap_next   = '0;
                            end
                        end
                        else if (held_valid_next)
                        begin
                            // chain the held pixel with no gap
                            shift_next      = held_pixel_reg;
                            bits_left_next  = BL_W'(PIXEL_BITS);
                            cur_last_next   = held_last_reg;
                            held_valid_next = 1'b0;
                            phase_next      = PH_BITS;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                end
                else
                begin
                    tick_next = tick_inc;
                end
            end
            else if (phase_next == PH_GAP)
            begin
                gap_inc  = gap_reg + GAP_WIDTH'(1);
                gap_next = gap_inc;
                if (gap_inc >= reset_ticks)
                begin
                    result.frame_done = 1'b1;
                    phase_next        = PH_IDLE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg      <= '0;
            bits_left_reg  <= '0;
            tick_reg       <= '0;
            phase_reg      <= PH_IDLE;
            gap_reg        <= '0;
            held_valid_reg <= 1'b0;
            held_last_reg  <= 1'b0;
            cur_last_reg   <= 1'b0;
        end
        else if (step_en)
        begin
            shift_reg      <= shift_next;
            bits_left_reg  <= bits_left_next;
            tick_reg       <= tick_next;
            phase_reg      <= phase_next;
            gap_reg        <= gap_next;
            held_valid_reg <= held_valid_next;
            held_last_reg  <= held_last_next;
            cur_last_reg   <= cur_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            held_pixel_reg <= held_pixel_next;
        end
    end

endmodule

>>> hdl/rgbw_checker.sv
// ----------------------------------------------------------------------------
// rgbw_checker
// Port-level checks on the result channel of the serializer.
// ----------------------------------------------------------------------------
module rgbw_checker
(
    input logic clk,
    input logic rst_n,
    input logic result_valid,
    input logic result_ready,
    input logic line_level,
    input logic pixel_taken,
    input logic busy_res,
    input logic frame_done
);

    // hold a stalled transaction
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid
            && $stable(line_level) && $stable(pixel_taken)
            && $stable(busy_res) && $stable(frame_done))
        else $error("stalled result changed");

    a_taken_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(pixel_taken && frame_done))
        else $error("pixel accept and frame end in one result");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && frame_done |-> busy_res)
        else $error("frame end reported on an idle line");

    a_level_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && line_level |-> busy_res)
        else $error("line driven high while idle");

endmodule

bind rgbw_led_pulse_serializer rgbw_checker u_rgbw_checker (.*);
